FILE: src/ble_message_segmenter_defines.svh
// assertion macros used by the checker file
`ifndef BLE_MESSAGE_SEGMENTER_DEFINES_SVH
`define BLE_MESSAGE_SEGMENTER_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define BMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define BMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bms_pkg.sv
package bms_pkg;

	// segment geometry
	localparam int unsigned SEG_PAYLOAD = 19;
	localparam int unsigned CNT_W       = $clog2(SEG_PAYLOAD + 1);
	localparam int unsigned IDX_W       = $clog2(SEG_PAYLOAD);
	localparam int unsigned DATA_W      = 8;
	localparam int unsigned PTYPE_W     = 7;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic store_held;
		logic hdr;
		logic data;
		logic final_seg;
		logic clear;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic in_end;
		logic end_held;
		logic out_free;
		logic last;
	} stat_t;

endpackage

FILE: src/bms_if.sv
// input channel: one message byte per beat
interface bms_in_if;
	logic                          valid;
	logic                          ready;
	logic [bms_pkg::DATA_W-1:0]    data_byte;
	logic                          message_end;
	logic [bms_pkg::PTYPE_W-1:0]   parse_type;

	modport source (output valid, data_byte, message_end, parse_type, input ready);
	modport sink (input valid, data_byte, message_end, parse_type, output ready);
endinterface

// output channel: one segment byte per beat
interface bms_out_if;
	logic                          valid;
	logic                          ready;
	logic [bms_pkg::DATA_W-1:0]    seg_byte;
	logic                          is_header;
	logic                          segment_end;
	logic                          message_done;

	modport source (output valid, seg_byte, is_header, segment_end, message_done, input ready);
	modport sink (input valid, seg_byte, is_header, segment_end, message_done, output ready);
endinterface

FILE: src/bms_ram.sv
module bms_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/bms_datapath.sv
module bms_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bms_pkg::DATA_W-1:0]    in_data_byte,
	input  logic                          in_message_end,
	input  logic [bms_pkg::PTYPE_W-1:0]   in_parse_type,
	input  bms_pkg::cmd_t                 cmd,
	output bms_pkg::stat_t                stat,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [bms_pkg::DATA_W-1:0]    out_seg_byte,
	output logic                          out_is_header,
	output logic                          out_segment_end,
	output logic                          out_message_done
);

	logic [bms_pkg::CNT_W-1:0]   count_q;
	logic                        first_q;
	logic [bms_pkg::DATA_W-1:0]  byte_q;
	logic                        end_q;
	logic [bms_pkg::PTYPE_W-1:0] ptype_q;
	logic [bms_pkg::IDX_W-1:0]   idx_q;

	logic                        out_valid_q;
	logic [bms_pkg::DATA_W-1:0]  out_byte_q;
	logic                        out_hdr_q;
	logic                        out_send_q;
	logic                        out_done_q;

	logic                        full;
	logic                        last;
	logic                        out_free;
	logic                        advance;
	logic [bms_pkg::DATA_W-1:0]  hdr_byte;

	logic                        ram_we;
	logic [bms_pkg::IDX_W-1:0]   ram_waddr;
	logic [bms_pkg::DATA_W-1:0]  ram_wdata;
	logic [bms_pkg::IDX_W-1:0]   ram_raddr;
	logic [bms_pkg::DATA_W-1:0]  ram_rdata;

	// buffer and output stage conditions
	assign full     = (count_q == bms_pkg::CNT_W'(bms_pkg::SEG_PAYLOAD));
	assign last     = ((bms_pkg::CNT_W'(idx_q) + bms_pkg::CNT_W'(1)) == count_q);
	assign out_free = !out_valid_q || out_ready;
	assign advance  = (cmd.hdr || cmd.data) && out_free;

	assign stat.full     = full;
	assign stat.in_end   = in_message_end;
	assign stat.end_held = end_q;
	assign stat.out_free = out_free;
	assign stat.last     = last;

	// header byte: parse type only on the final segment
	assign hdr_byte = cmd.final_seg ? {ptype_q, first_q} : {{bms_pkg::PTYPE_W{1'b0}}, first_q};

	// buffer write: direct from input, or the held byte after a flush
	assign ram_we    = (cmd.accept && !full) || cmd.store_held;
	assign ram_waddr = cmd.store_held ? '0 : count_q[bms_pkg::IDX_W-1:0];
	assign ram_wdata = cmd.store_held ? byte_q : in_data_byte;

	// read address runs one ahead of the byte being loaded
	always_comb begin
		ram_raddr = '0;
		if (cmd.data) begin
			if (advance && !last) begin
				ram_raddr = idx_q + bms_pkg::IDX_W'(1);
			end else begin
				ram_raddr = idx_q;
			end
		end
	end

	bms_ram #(
		.WIDTH (bms_pkg::DATA_W),
		.DEPTH (bms_pkg::SEG_PAYLOAD)
	) u_bms_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// fill count and first-segment flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			first_q <= 1'b1;
		end else if (cmd.clear) begin
			count_q <= '0;
			first_q <= 1'b1;
		end else if (cmd.store_held) begin
			count_q <= bms_pkg::CNT_W'(1);
			first_q <= 1'b0;
		end else if (cmd.accept && !full) begin
			count_q <= count_q + bms_pkg::CNT_W'(1);
		end
	end

	// input beat held for flush and final header
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q  <= in_data_byte;
			end_q   <= in_message_end;
			ptype_q <= in_parse_type;
		end
	end

	// read index within the segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.hdr) begin
			idx_q <= '0;
		end else if (cmd.data && out_free) begin
			idx_q <= idx_q + bms_pkg::IDX_W'(1);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			if (cmd.hdr) begin
				out_byte_q <= hdr_byte;
				out_hdr_q  <= 1'b1;
				out_send_q <= 1'b0;
				out_done_q <= 1'b0;
			end else begin
				out_byte_q <= ram_rdata;
				out_hdr_q  <= 1'b0;
				out_send_q <= last;
				out_done_q <= last && cmd.final_seg;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_seg_byte     = out_byte_q;
	assign out_is_header    = out_hdr_q;
	assign out_segment_end  = out_send_q;
	assign out_message_done = out_done_q;

endmodule

FILE: src/bms_ctrl.sv
module bms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bms_pkg::stat_t stat,
	output bms_pkg::cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_HDR   = 2'd1;
	localparam logic [1:0] ST_DATA  = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       final_q;
	logic       final_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// commands to the datapath
	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		cmd.hdr        = (state_q == ST_HDR);
		cmd.data       = (state_q == ST_DATA);
		cmd.store_held = (state_q == ST_WRITE);
		cmd.final_seg  = final_q;
		cmd.clear      = (state_q == ST_DATA) && stat.out_free && stat.last && final_q;
	end

	// sequencing of segment emission
	always_comb begin
		state_d = state_q;
		final_d = final_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (stat.full) begin
						state_d = ST_HDR;
						final_d = 1'b0;
					end else if (stat.in_end) begin
						state_d = ST_HDR;
						final_d = 1'b1;
					end
				end
			end
			ST_HDR: begin
				if (stat.out_free) begin
					state_d = ST_DATA;
				end
			end
			ST_DATA: begin
				if (stat.out_free && stat.last) begin
					state_d = final_q ? ST_IDLE : ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (stat.end_held) begin
					state_d = ST_HDR;
					final_d = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
		end
	end

endmodule

FILE: src/ble_message_segmenter.sv
// A byte that does not end a message and finds room in the buffer is stored and the input stays ready.
// A flush of a full buffer sends the header and the SEG_PAYLOAD held bytes, then stores the new byte;
// a final segment sends the header and its n bytes, read through the registered port of the buffer RAM.
// The triggering beat moves the sequencer to the header state, which loads the header into the output register.
// Reset (arst_n low) empties the buffer count and marks the next segment as first.
module ble_message_segmenter (
	input logic     clk,
	input logic     arst_n,
	bms_in_if.sink  in_ch,
	bms_out_if.source out_ch
);

	bms_pkg::cmd_t  cmd;
	bms_pkg::stat_t stat;

	// sequencer
	bms_ctrl u_bms_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// buffer, header build and output register
	bms_datapath u_bms_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_data_byte     (in_ch.data_byte),
		.in_message_end   (in_ch.message_end),
		.in_parse_type    (in_ch.parse_type),
		.cmd              (cmd),
		.stat             (stat),
		.out_ready        (out_ch.ready),
		.out_valid        (out_ch.valid),
		.out_seg_byte     (out_ch.seg_byte),
		.out_is_header    (out_ch.is_header),
		.out_segment_end  (out_ch.segment_end),
		.out_message_done (out_ch.message_done)
	);

endmodule

FILE: src/bms_checker.sv
`include "ble_message_segmenter_defines.svh"

module bms_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_message_end,
	input logic out_valid,
	input logic out_ready,
	input logic out_is_header,
	input logic out_segment_end,
	input logic out_message_done
);

	// no input is taken while a header waits on the output
	`BMS_ASSERT_NOW(a_hdr_blocks_in, out_valid && out_is_header, !in_ready, "input ready with header pending")

	// after an accepted message end beat the input is not ready
	`BMS_ASSERT_NEXT(a_end_stalls_in, in_valid && in_ready && in_message_end, !in_ready, "input ready after message end")

	// an accepted header is not directly followed by another header
	`BMS_ASSERT_NEXT(a_hdr_then_data, out_valid && out_ready && out_is_header, !(out_valid && out_is_header), "two headers in a row")

	// message done only on the last payload beat of a segment
	`BMS_ASSERT_NOW(a_done_is_seg_end, out_valid && out_message_done, out_segment_end && !out_is_header, "message done off a segment end")

endmodule

bind ble_message_segmenter bms_checker u_bms_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.in_message_end   (in_ch.message_end),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_is_header    (out_ch.is_header),
	.out_segment_end  (out_ch.segment_end),
	.out_message_done (out_ch.message_done)
);

FILE: tb/ble_message_segmenter_tb.sv
module ble_message_segmenter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned LONG_HOLD      = 400;
	localparam int unsigned TAIL_CYCLES    = 40;
	localparam int unsigned RANDOM_ITEMS   = 180;
	localparam int unsigned MAX_REPORTS    = 10;

	// one output beat as the block presents it
	typedef struct packed {
		logic [bms_pkg::DATA_W-1:0] seg_byte;
		logic                       is_header;
		logic                       segment_end;
		logic                       message_done;
	} seg_beat_t;

	// segmenting predictor plus queue of beats still owed by the block
	class segment_scoreboard;
		logic [bms_pkg::DATA_W-1:0] held [bms_pkg::SEG_PAYLOAD];
		int unsigned                held_count;
		bit                         opens_message;
		seg_beat_t                  owed_beats[$];
		int unsigned                errors;

		function new();
			held_count    = 0;
			opens_message = 1'b1;
			errors        = 0;
		endfunction

		function int unsigned outstanding();
			return owed_beats.size();
		endfunction

		// header beat, then the held bytes
		function void push_segment(logic [bms_pkg::DATA_W-1:0] header, bit final_seg);
			seg_beat_t b;
			b = '{seg_byte: header, is_header: 1'b1, segment_end: 1'b0, message_done: 1'b0};
			owed_beats.push_back(b);
			for (int i = 0; i < held_count; i++) begin
				b.seg_byte     = held[i];
				b.is_header    = 1'b0;
				b.segment_end  = (i == held_count - 1);
				b.message_done = (i == held_count - 1) && final_seg;
				owed_beats.push_back(b);
			end
		endfunction

		// accepted input beat
		function void note_byte(logic [bms_pkg::DATA_W-1:0] data, logic msg_end,
				logic [bms_pkg::PTYPE_W-1:0] ptype);
			// full buffer flushes as a non-final segment before storing
			if (held_count >= bms_pkg::SEG_PAYLOAD) begin
				push_segment({{(bms_pkg::DATA_W-1){1'b0}}, opens_message}, 1'b0);
				opens_message = 1'b0;
				held_count    = 0;
			end
			held[held_count] = data;
			held_count++;
			// message end closes out with the parse type in the header
			if (msg_end) begin
				push_segment({ptype, opens_message}, 1'b1);
				held_count    = 0;
				opens_message = 1'b1;
			end
		endfunction

		// accepted output beat against the oldest owed beat
		function void check_beat(seg_beat_t got);
			seg_beat_t want;
			if (owed_beats.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected beat byte=%h hdr=%b seg_end=%b done=%b",
						$realtime, got.seg_byte, got.is_header, got.segment_end,
						got.message_done);
				return;
			end
			want = owed_beats.pop_front();
			if (got.seg_byte !== want.seg_byte || got.is_header !== want.is_header ||
					got.segment_end !== want.segment_end ||
					got.message_done !== want.message_done) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: mismatch exp byte=%h hdr=%b seg_end=%b done=%b, %s%h %b %b %b",
						$realtime, want.seg_byte, want.is_header, want.segment_end,
						want.message_done, "got ", got.seg_byte, got.is_header,
						got.segment_end, got.message_done);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bms_in_if  in_bus ();
	bms_out_if out_bus ();

	ble_message_segmenter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (out_bus)
	);

	segment_scoreboard sb = new();

	bit          hold_request;
	int unsigned idle_cycles = 0;

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// gap length: mostly short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// output beat monitor
	always @(posedge clk) begin
		if (arst_n && out_bus.valid && out_bus.ready)
			sb.check_beat('{seg_byte: out_bus.seg_byte, is_header: out_bus.is_header,
				segment_end: out_bus.segment_end, message_done: out_bus.message_done});
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (!arst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stalls in phases, one long hold on request
	initial begin
		int unsigned stall_left;
		int unsigned stall_pct;
		int unsigned phase_left;
		bit          hold_taken;
		stall_left    = 0;
		stall_pct     = 0;
		phase_left    = 0;
		hold_taken    = 1'b0;
		out_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 25;
					default: stall_pct = 60;
				endcase
				phase_left = $urandom_range(50, 200);
			end
			phase_left--;
			if (hold_request && !hold_taken) begin
				out_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_taken = 1'b1;
			end else if (stall_left > 0) begin
				out_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				out_bus.ready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct)
					stall_left = pick_gap();
			end
		end
	end

	// offer one input beat, wait for it to be taken, then drop valid for the requested gap
	task automatic send_byte(input logic [bms_pkg::DATA_W-1:0] data, input logic msg_end,
			input logic [bms_pkg::PTYPE_W-1:0] ptype, input int unsigned gap);
		in_bus.valid       <= 1'b1;
		in_bus.data_byte   <= data;
		in_bus.message_end <= msg_end;
		in_bus.parse_type  <= ptype;
		@(posedge clk);
		while (!in_bus.ready)
			@(posedge clk);
		sb.note_byte(data, msg_end, ptype);
		if (gap > 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait until every owed beat has come out
	task automatic drain();
		in_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// message of random content, random parse type on every beat
	task automatic send_message(input int unsigned len, input bit quiet);
		for (int unsigned i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), (i == len - 1),
				7'($urandom_range(0, 127)), quiet ? 0 : pick_gap());
	endtask

	// stimulus
	initial begin
		int unsigned sent;
		int unsigned len;
		int unsigned r;
		bit          paused_mid;
		sent               = 0;
		paused_mid         = 1'b0;
		arst_n             = 1'b0;
		in_bus.valid       = 1'b0;
		in_bus.data_byte   = '0;
		in_bus.message_end = 1'b0;
		in_bus.parse_type  = '0;
		hold_request       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte messages at the field extremes
		send_byte(8'h00, 1'b1, 7'h00, 0);
		send_byte(8'hFF, 1'b1, 7'h7F, 1);
		// short message with stray parse type on the inner bytes
		send_byte(8'hA5, 1'b0, 7'h7F, 0);
		send_byte(8'h5A, 1'b0, 7'h55, 0);
		send_byte(8'h01, 1'b0, 7'h2A, 2);
		send_byte(8'h80, 1'b1, 7'h2A, 0);
		// message of exactly one full segment, no empty segment after it
		for (int unsigned i = 0; i < bms_pkg::SEG_PAYLOAD; i++)
			send_byte((i % 2) ? 8'hFF : i[7:0], (i == bms_pkg::SEG_PAYLOAD - 1), 7'h55, 0);
		sent += 6 + bms_pkg::SEG_PAYLOAD;

		// sender pauses until the block is empty
		drain();

		// long receiver hold while a long message keeps coming
		hold_request = 1'b1;
		send_message(45, 1'b1);
		sent += 45;

		// random messages, lengths biased to segment boundaries
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				len = bms_pkg::SEG_PAYLOAD * $urandom_range(1, 3);
			else if (r < 22)
				len = bms_pkg::SEG_PAYLOAD + $urandom_range(0, 2) - 1;
			else if (r < 88)
				len = $urandom_range(1, 25);
			else
				len = $urandom_range(26, 60);
			send_message(len, ($urandom_range(0, 3) == 0));
			sent += len;
			if (!paused_mid && sent >= RANDOM_ITEMS / 2) begin
				paused_mid = 1'b1;
				drain();
			end
		end

		// end of run: everything owed has come, then a quiet tail
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
